// ===== rtl/blr_pkg.sv =====
package blr_pkg;

  // Sequencer states of the line walker
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_INIT,
    ST_RUN
  } blr_state_e;

  // Mode of the shared error-term unit
  typedef struct packed {
    logic init;    // load 2*minor - major instead of stepping
    logic rising;  // minor axis steps when err >= 0, else only when err > 0
  } blr_step_ctrl_t;

endpackage

// ===== rtl/bresenham_line_rasterizer.sv =====
// Bresenham line rasterizer: takes a word of two endpoints and emits every pixel of the
// line, left to right, one output word per pixel, with final_pixel_o set on the last one.
// A line of N pixels (N = max(|dx|, |dy|) + 1) occupies the block from one input accept
// to the earliest next one: the accept, a setup state (swap, deltas, octant), a state
// that loads the error term, then one pixel per cycle while out_ready_i is high. The
// per-pixel rate is set by the single error-term adder, which advances once for each
// pixel taken but the last. Input is not accepted while a line is being walked.
module bresenham_line_rasterizer #(
  parameter int COORD_BITS = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  final_pixel_o
);
  import blr_pkg::*;

  localparam int ErrBits = COORD_BITS + 3;

  blr_state_e state_q, state_d;

  logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [COORD_BITS-1:0] x_q, y_q;
  logic [COORD_BITS-1:0] major_q, minor_q, cnt_q;
  logic [ErrBits-1:0]    err_q;
  logic                  steep_q, down_q;

  // setup values
  logic [COORD_BITS-1:0] x0, y0, x1, y1, dx, ady;
  logic                  down, steep;

  // shared unit
  blr_step_ctrl_t     step_ctrl;
  logic [ErrBits-1:0] err_next;
  logic               adv;

  logic in_fire, out_fire;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = (state_q == ST_RUN);
  assign pixel_x_o     = x_q;
  assign pixel_y_o     = y_q;
  assign final_pixel_o = (cnt_q == '0);
  assign in_fire       = in_valid_i && in_ready_o;
  assign out_fire      = out_valid_o && out_ready_i;

  // Swap so the line runs left to right, then pick the major axis
  always_comb begin
    if (sx_q > ex_q) begin
      x0 = ex_q; y0 = ey_q; x1 = sx_q; y1 = sy_q;
    end else begin
      x0 = sx_q; y0 = sy_q; x1 = ex_q; y1 = ey_q;
    end
    dx    = x1 - x0;
    down  = (y1 < y0);
    ady   = down ? (y0 - y1) : (y1 - y0);
    steep = (ady > dx);
  end

  assign step_ctrl.init   = (state_q == ST_INIT);
  assign step_ctrl.rising = !down_q;

  blr_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .ctrl_i  (step_ctrl),
    .err_i   (err_q),
    .major_i (major_q),
    .minor_i (minor_q),
    .err_o   (err_next),
    .adv_o   (adv)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_INIT;
      ST_INIT:  state_d = ST_RUN;
      ST_RUN:   if (out_fire && final_pixel_o) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sx_q <= start_x_i;
          sy_q <= start_y_i;
          ex_q <= end_x_i;
          ey_q <= end_y_i;
        end
      end
      ST_SETUP: begin
        x_q     <= x0;
        y_q     <= y0;
        down_q  <= down;
        steep_q <= steep;
        major_q <= steep ? ady : dx;
        minor_q <= steep ? dx : ady;
        cnt_q   <= steep ? ady : dx;
      end
      ST_INIT: begin
        err_q <= err_next;
      end
      ST_RUN: begin
        // step along the major axis, minor axis when the error term says so
        if (out_fire && !final_pixel_o) begin
          err_q <= err_next;
          cnt_q <= cnt_q - 1'b1;
          if (steep_q) begin
            y_q <= down_q ? (y_q - 1'b1) : (y_q + 1'b1);
            if (adv) x_q <= x_q + 1'b1;
          end else begin
            x_q <= x_q + 1'b1;
            if (adv) y_q <= down_q ? (y_q - 1'b1) : (y_q + 1'b1);
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a line is being emitted");

  a_final_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && final_pixel_o |=> in_ready_o)
    else $error("block not free after the final pixel");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !final_pixel_o |=> out_valid_o && (cnt_q == $past(cnt_q) - 1'b1))
    else $error("pixel count did not step");

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_SETUP) && !out_valid_o)
    else $error("accepted word did not enter setup");

endmodule

// ===== rtl/blr_step.sv =====
module blr_step #(
  parameter int COORD_BITS = 6
) (
  input  blr_pkg::blr_step_ctrl_t  ctrl_i,
  input  logic [COORD_BITS+2:0]    err_i,
  input  logic [COORD_BITS-1:0]    major_i,
  input  logic [COORD_BITS-1:0]    minor_i,
  output logic [COORD_BITS+2:0]    err_o,
  output logic                     adv_o
);
  import blr_pkg::*;

  localparam int ErrBits = COORD_BITS + 3;

  logic [ErrBits-1:0] base;
  logic [ErrBits-1:0] twice_minor;
  logic [ErrBits-1:0] sub;
  logic               adv;

  // One adder: err' = base + 2*minor - sub
  always_comb begin
    twice_minor = {2'b00, minor_i, 1'b0};
    // falling lines break the tie toward the major axis only
    adv = !err_i[ErrBits-1] && (ctrl_i.rising || (err_i != '0));
    if (ctrl_i.init) begin
      base  = '0;
      sub   = {3'b000, major_i};
      adv_o = 1'b0;
    end else begin
      base  = err_i;
      sub   = adv ? {2'b00, major_i, 1'b0} : '0;
      adv_o = adv;
    end
    err_o = base + twice_minor - sub;
  end

endmodule

// ===== verif/tb_bresenham_line_rasterizer.sv =====
module tb_bresenham_line_rasterizer;

  localparam int COORD_BITS = 6;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  // one expected output word: a pixel of the line
  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } pixel_t;

  // one line request; drain makes the sender wait for an empty scoreboard first
  typedef struct {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    bit                    drain;
  } line_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [COORD_BITS-1:0] start_x_i = '0;
  logic [COORD_BITS-1:0] start_y_i = '0;
  logic [COORD_BITS-1:0] end_x_i = '0;
  logic [COORD_BITS-1:0] end_y_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [COORD_BITS-1:0] pixel_x_o;
  logic [COORD_BITS-1:0] pixel_y_o;
  logic                  final_pixel_o;

  line_req_t pending_lines[$];
  pixel_t    exp_pixels[$];

  // handshake flags from the rising edge, read by the drivers at the falling edge
  bit line_accepted;
  bit pixel_taken;
  int lines_taken;
  int fault_cnt;

  // sender and receiver pacing
  int tx_gap, tx_phase;
  bit tx_quiet;
  int rx_gap, rx_phase, hold_left;
  bit rx_quiet, hold_done;

  bresenham_line_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .final_pixel_o(final_pixel_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_span(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 20);
  endfunction

  function automatic int clip(input int v);
    if (v < 0) return 0;
    if (v > COORD_MAX) return COORD_MAX;
    return v;
  endfunction

  // walk the line as the block should and queue its pixels
  function automatic void trace_line(input logic [COORD_BITS-1:0] sx, sy, ex, ey);
    int x0, y0, x1, y1, x, y, dx, dy, err, t;
    pixel_t line_pix[$];
    pixel_t px;
    x0 = sx;
    y0 = sy;
    x1 = ex;
    y1 = ey;
    // run left to right
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
      t = y0; y0 = y1; y1 = t;
    end
    x = x0;
    y = y0;
    dx = x1 - x0;
    dy = y1 - y0;
    line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
    if (dx == 0) begin
      // vertical, either direction
      while (y != y1) begin
        y += (y < y1) ? 1 : -1;
        line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
      end
    end else if (dy == 0) begin
      while (x < x1) begin
        x++;
        line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
      end
    end else if (dy > 0 && dy <= dx) begin
      // shallow rising
      err = 2 * dy - dx;
      while (x < x1) begin
        x++;
        if (err < 0) begin
          err += 2 * dy;
        end else begin
          y++;
          err += 2 * (dy - dx);
        end
        line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
      end
    end else if (dy < 0 && dy >= -dx) begin
      // shallow falling
      err = 2 * dy + dx;
      while (x < x1) begin
        x++;
        if (err >= 0) begin
          err += 2 * dy;
        end else begin
          y--;
          err += 2 * (dx + dy);
        end
        line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
      end
    end else if (dy < 0) begin
      // steep falling
      err = -(2 * dx + dy);
      while (y > y1) begin
        y--;
        if (err >= 0) begin
          err -= 2 * dx;
        end else begin
          x++;
          err -= 2 * (dx + dy);
        end
        line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
      end
    end else begin
      // steep rising
      err = 2 * dx - dy;
      while (y < y1) begin
        y++;
        if (err < 0) begin
          err += 2 * dx;
        end else begin
          x++;
          err += 2 * (dx - dy);
        end
        line_pix.push_back('{x[COORD_BITS-1:0], y[COORD_BITS-1:0], 1'b0});
      end
    end
    line_pix[line_pix.size() - 1].last = 1'b1;
    foreach (line_pix[i]) begin
      px = line_pix[i];
      exp_pixels.push_back(px);
    end
  endfunction

  function automatic void log_fault(input string msg);
    fault_cnt++;
    if (fault_cnt <= 10) $display("%0t: %s", $time, msg);
  endfunction

  task automatic add_line(input int sx, sy, ex, ey, input bit drain = 1'b0);
    line_req_t req;
    req.sx = sx[COORD_BITS-1:0];
    req.sy = sy[COORD_BITS-1:0];
    req.ex = ex[COORD_BITS-1:0];
    req.ey = ey[COORD_BITS-1:0];
    req.drain = drain;
    pending_lines.push_back(req);
  endtask

  // monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin
    pixel_t want;
    line_accepted = rst_ni && in_valid_i && in_ready_o;
    pixel_taken = rst_ni && out_valid_o && out_ready_i;
    if (line_accepted) begin
      trace_line(start_x_i, start_y_i, end_x_i, end_y_i);
      lines_taken++;
    end
    if (pixel_taken) begin
      if (exp_pixels.size() == 0) begin
        log_fault($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                            pixel_x_o, pixel_y_o, final_pixel_o));
      end else begin
        want = exp_pixels.pop_front();
        if (pixel_x_o !== want.x || pixel_y_o !== want.y || final_pixel_o !== want.last)
          log_fault($sformatf("pixel mismatch: exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                              want.x, want.y, want.last,
                              pixel_x_o, pixel_y_o, final_pixel_o));
      end
    end
  end

  // sender: one line word at a time, held until accepted
  always @(negedge clk_i) begin
    line_req_t req;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !line_accepted) begin
      // word still waiting
    end else begin
      if (tx_phase == 0) begin
        tx_quiet = ($urandom_range(0, 3) == 0);
        tx_phase = $urandom_range(50, 300);
      end else begin
        tx_phase--;
      end
      if (line_accepted) tx_gap = idle_span(tx_quiet);
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_lines.size() != 0 &&
                   (!pending_lines[0].drain || exp_pixels.size() == 0)) begin
        req = pending_lines.pop_front();
        start_x_i  <= req.sx;
        start_y_i  <= req.sy;
        end_x_i    <= req.ex;
        end_y_i    <= req.ey;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus one long hold-off mid-run
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_quiet = ($urandom_range(0, 3) == 0);
        rx_phase = $urandom_range(50, 300);
      end else begin
        rx_phase--;
      end
      if (!hold_done && lines_taken >= 40) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_gap == 0 && (pixel_taken || $urandom_range(0, 19) == 0))
          rx_gap = idle_span(rx_quiet);
        if (rx_gap > 0) begin
          rx_gap--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sx, sy, ex, ey, len, shape;
    bit up;
    // corner points, every octant, swapped endpoints, full-length lines
    add_line(0, 0, 0, 0);
    add_line(63, 63, 63, 63);
    add_line(5, 10, 5, 40);
    add_line(20, 60, 20, 3);
    add_line(0, 63, 63, 63);
    add_line(63, 0, 0, 0);
    add_line(0, 0, 63, 63);
    add_line(0, 63, 63, 0);
    add_line(63, 0, 0, 63);
    add_line(2, 5, 40, 17);
    add_line(3, 50, 60, 31);
    add_line(10, 2, 17, 61);
    add_line(30, 62, 41, 0);
    add_line(50, 20, 10, 30);
    add_line(45, 10, 40, 60);
    add_line(0, 0, 63, 1);
    add_line(0, 0, 1, 63);
    add_line(63, 0, 62, 63);
    add_line(7, 7, 8, 8);
    add_line(8, 9, 9, 8);
    add_line(0, 32, 63, 0);
    add_line(31, 0, 32, 63);
    add_line(40, 63, 40, 0);

    for (int i = 0; i < 230; i++) begin
      sx = $urandom_range(0, COORD_MAX);
      sy = $urandom_range(0, COORD_MAX);
      shape = $urandom_range(0, 9);
      if (shape <= 3) begin
        ex = $urandom_range(0, COORD_MAX);
        ey = $urandom_range(0, COORD_MAX);
      end else if (shape == 4) begin
        ex = sx;
        ey = $urandom_range(0, COORD_MAX);
      end else if (shape == 5) begin
        ex = $urandom_range(0, COORD_MAX);
        ey = sy;
      end else if (shape == 6) begin
        // 45 degree line, either slope
        up = $urandom_range(0, 1);
        len = $urandom_range(0, COORD_MAX);
        if (len > COORD_MAX - sx) len = COORD_MAX - sx;
        if (up && len > COORD_MAX - sy) len = COORD_MAX - sy;
        if (!up && len > sy) len = sy;
        ex = sx + len;
        ey = up ? sy + len : sy - len;
      end else begin
        // short line near the start point
        ex = clip(sx + $urandom_range(0, 16) - 8);
        ey = clip(sy + $urandom_range(0, 16) - 8);
      end
      if ($urandom_range(0, 1))
        add_line(ex, ey, sx, sy, i == 0 || i == 120);
      else
        add_line(sx, sy, ex, ey, i == 0 || i == 120);
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // checked at the rising edge, where the sender's valid has settled
    while (pending_lines.size() != 0 || in_valid_i || exp_pixels.size() != 0)
      @(posedge clk_i);
    repeat (16) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("bresenham_line_rasterizer regression: pass");
    end else begin
      $display("bresenham_line_rasterizer regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("bresenham_line_rasterizer regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/blr_pkg.sv
rtl/blr_step.sv
rtl/bresenham_line_rasterizer.sv
verif/tb_bresenham_line_rasterizer.sv
